### rtl/integer_square_root_defines.svh
// ----------------------------------------------------------------------------
// integer_square_root_defines
// Assertion macros shared by the integer square root RTL.
// ----------------------------------------------------------------------------
`ifndef INTEGER_SQUARE_ROOT_DEFINES_SVH
`define INTEGER_SQUARE_ROOT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ISQRT_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("isqrt assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ISQRT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("isqrt assertion failed");

`endif

### rtl/isqrt_pkg.sv
// ----------------------------------------------------------------------------
// isqrt_pkg
// Widths and the stage word type of the integer square root pipeline.
// ----------------------------------------------------------------------------
package isqrt_pkg;

    // Width of the two's complement operand (8..64).
    localparam int OPERAND_BITS = 64;
    // One root bit resolves per stage.
    localparam int ROOT_BITS    = OPERAND_BITS / 2;
    localparam int STAGES       = ROOT_BITS;
    // Fixed width of the root port.
    localparam int ROOT_W       = 32;

    typedef struct packed {
        logic [OPERAND_BITS-1:0] rem;
        logic [OPERAND_BITS-1:0] res;
        logic                    derr;
    } t_stage_data;

endpackage

### rtl/isqrt_stage.sv
// ----------------------------------------------------------------------------
// isqrt_stage
// One restoring digit step of the square root: trial subtract at one bit
// position, registered, with an elastic valid/ready handshake.
// ----------------------------------------------------------------------------
module isqrt_stage (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  isqrt_pkg::t_stage_data            i_data,
    input  logic [isqrt_pkg::OPERAND_BITS-1:0] i_bit,
    output logic                              o_valid,
    input  logic                              i_ready,
    output isqrt_pkg::t_stage_data            o_data
);

    logic                              r_valid;
    isqrt_pkg::t_stage_data            r_data;
    isqrt_pkg::t_stage_data            n_data;
    logic [isqrt_pkg::OPERAND_BITS-1:0] w_trial;
    logic                              w_take;

    assign o_ready = !r_valid || i_ready;
    assign w_trial = i_data.res + i_bit;
    assign w_take  = i_data.rem >= w_trial;

    always_comb begin
        n_data.derr = i_data.derr;
        if (w_take) begin
            n_data.rem = i_data.rem - w_trial;
            n_data.res = (i_data.res >> 1) + i_bit;
        end else begin
            n_data.rem = i_data.rem;
            n_data.res = i_data.res >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Advance the payload only on a taken word; hold it while stalled.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

### rtl/integer_square_root.sv
// ----------------------------------------------------------------------------
// integer_square_root
// Truncated square root of a signed operand, one root bit per pipeline stage.
// ----------------------------------------------------------------------------
// Returns floor(sqrt(operand)) for each input word, reading the low
// OPERAND_BITS bits of i_operand as two's complement. A negative operand
// gives a root of zero with o_domain_error set. The root is built by the
// restoring digit-by-digit method, one bit per register stage, so there are
// ROOT_BITS = OPERAND_BITS/2 stages (32 at the default width). A word enters
// every cycle while the output side keeps taking results. Each word passes
// through the stage registers in order, and the last stage's register
// doubles as the output register. Each stage holds its word when the stage
// after it is full and stalled, so back-pressure ripples upstream through
// the ready chain and nothing is dropped or repeated. Words leave in the
// order they arrived. The block keeps no state between words.
// ----------------------------------------------------------------------------
`include "integer_square_root_defines.svh"

module integer_square_root (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [63:0]                       i_operand,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [isqrt_pkg::ROOT_W-1:0]      o_root,
    output logic                              o_domain_error
);

    logic                               w_valid [0:isqrt_pkg::STAGES];
    logic                               w_ready [0:isqrt_pkg::STAGES];
    isqrt_pkg::t_stage_data             w_data  [0:isqrt_pkg::STAGES];
    logic [isqrt_pkg::OPERAND_BITS-1:0] w_bit   [0:isqrt_pkg::STAGES-1];
    logic                               w_sign;

    // Sign of the operand at its configured width.
    assign w_sign = i_operand[isqrt_pkg::OPERAND_BITS-1];

    // Feed the first stage; a negative operand enters with a zero remainder,
    // so the pipeline naturally yields a zero root for it.
    assign w_valid[0]     = i_valid;
    assign o_ready        = w_ready[0];
    assign w_data[0].rem  = w_sign ? '0 : i_operand[isqrt_pkg::OPERAND_BITS-1:0];
    assign w_data[0].res  = '0;
    assign w_data[0].derr = w_sign;

    genvar g;
    generate
        for (g = 0; g < isqrt_pkg::STAGES; g++) begin : g_stage
            // Trial bit of this stage: 4^(ROOT_BITS-1-g), highest first.
            assign w_bit[g] = {{(isqrt_pkg::OPERAND_BITS-1){1'b0}}, 1'b1}
                              << (2 * (isqrt_pkg::ROOT_BITS - 1 - g));

            isqrt_stage u_stage (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_valid (w_valid[g]),
                .o_ready (w_ready[g]),
                .i_data  (w_data[g]),
                .i_bit   (w_bit[g]),
                .o_valid (w_valid[g+1]),
                .i_ready (w_ready[g+1]),
                .o_data  (w_data[g+1])
            );
        end
    endgenerate

    // Output side: the last stage is the output register.
    assign w_ready[isqrt_pkg::STAGES] = i_ready;
    assign o_valid        = w_valid[isqrt_pkg::STAGES];
    assign o_domain_error = w_data[isqrt_pkg::STAGES].derr;
    assign o_root         = (isqrt_pkg::ROOT_W)'(
                                w_data[isqrt_pkg::STAGES].res[isqrt_pkg::ROOT_BITS-1:0]);

    // A domain error always comes with a zero root.
    `ISQRT_ASSERT_SAME(a_derr_zero_root, i_clk, i_rst_n,
        o_valid && o_domain_error, o_root == '0)

    // A finished root leaves a remainder no larger than twice the root.
    `ISQRT_ASSERT_SAME(a_rem_bound, i_clk, i_rst_n,
        w_valid[isqrt_pkg::STAGES],
        w_data[isqrt_pkg::STAGES].rem <= (w_data[isqrt_pkg::STAGES].res << 1))

    // A negative word taken in lands in the first stage flagged.
    `ISQRT_ASSERT_NEXT(a_derr_entry, i_clk, i_rst_n,
        i_valid && o_ready && w_sign, w_valid[1] && w_data[1].derr)

endmodule

### verif/integer_square_root_tb.sv
// ----------------------------------------------------------------------------
// integer_square_root_tb
// Self-checking bench for the pipelined integer square root.
// ----------------------------------------------------------------------------
// Drive operand words through the valid/ready input channel and collect root
// words from the output channel. A small scoreboard class predicts each
// root from the accepted operand with its own digit-by-digit square root,
// then compares every returned word, field by field, in arrival order. Hit
// the corner operands first, then a long run of random operands biased
// toward perfect squares and their neighbors, short and negative values.
// Both channels idle in random bursts; the last stretch runs with no idling.
// ----------------------------------------------------------------------------
module integer_square_root_tb;

    localparam int RESET_CYCLES = 10;
    localparam int RANDOM_WORDS = 1700;
    // Run the tail of the random part with both sides always ready.
    localparam int QUIET_WORDS  = 200;
    // Hold off the sender until the pipe is empty this often.
    localparam int DRAIN_EVERY  = 400;
    localparam int SETTLE_CYCLES = isqrt_pkg::STAGES + 16;
    // Cycle budget for the whole run; the watchdog ends the run as a failure.
    localparam int CYCLE_LIMIT  = 600000;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_valid;
    logic                          o_ready;
    logic [63:0]                   i_operand;
    logic                          o_valid;
    logic                          i_ready;
    logic [isqrt_pkg::ROOT_W-1:0]  o_root;
    logic                          o_domain_error;

    // Set by the stimulus for the final stretch: no idling on either side.
    bit quiet;
    int cycle_count;

    typedef struct {
        logic [isqrt_pkg::ROOT_W-1:0] root;
        logic                         derr;
    } t_root_word;

    // ------------------------------------------------------------------------
    // Scoreboard: predict a root per accepted operand, check results in order.
    // ------------------------------------------------------------------------
    class root_ledger;
        t_root_word pending_roots[$];
        int         mismatches;

        // Restoring digit-by-digit square root of an unsigned value.
        function logic [63:0] floor_root(logic [63:0] value);
            logic [63:0] rem;
            logic [63:0] acc;
            logic [63:0] probe;
            rem   = value;
            acc   = '0;
            probe = 64'd1 << 62;
            while (probe > rem)
                probe = probe >> 2;
            while (probe != 0) begin
                if (rem >= acc + probe) begin
                    rem = rem - (acc + probe);
                    acc = (acc >> 1) + probe;
                end else begin
                    acc = acc >> 1;
                end
                probe = probe >> 2;
            end
            return acc;
        endfunction

        function void note_operand(logic [63:0] operand);
            logic [63:0] field;
            logic [63:0] full_root;
            t_root_word  want;
            // Keep only the operand width; its top bit is the sign.
            field = operand & (64'hFFFF_FFFF_FFFF_FFFF >> (64 - isqrt_pkg::OPERAND_BITS));
            if (field[isqrt_pkg::OPERAND_BITS-1]) begin
                want.root = '0;
                want.derr = 1'b1;
            end else begin
                full_root = floor_root(field);
                want.root = full_root[isqrt_pkg::ROOT_W-1:0];
                want.derr = 1'b0;
            end
            pending_roots.push_back(want);
        endfunction

        function void check_result(logic [isqrt_pkg::ROOT_W-1:0] root, logic derr);
            t_root_word want;
            if (pending_roots.size() == 0) begin
                $display("%0t: unexpected result word root=%0d domain_error=%b",
                         $time, root, derr);
                mismatches++;
                return;
            end
            want = pending_roots.pop_front();
            if (root !== want.root) begin
                $display("%0t: root mismatch expected %0d actual %0d",
                         $time, want.root, root);
                mismatches++;
            end
            if (derr !== want.derr) begin
                $display("%0t: domain_error mismatch expected %b actual %b",
                         $time, want.derr, derr);
                mismatches++;
            end
        endfunction

        function int pending();
            return pending_roots.size();
        endfunction
    endclass

    root_ledger ledger = new;

    integer_square_root uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_operand      (i_operand),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_root         (o_root),
        .o_domain_error (o_domain_error)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Abort on a hung pipe.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL integer_square_root");
            $finish;
        end
    end

    // Monitor both handshakes at the edge; values seen here are pre-update.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready)
                ledger.note_operand(i_operand);
            if (o_valid && i_ready)
                ledger.check_result(o_root, o_domain_error);
        end
    end

    // Receiver: stall in random bursts until the quiet stretch begins.
    initial begin
        i_ready <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        forever begin
            if (!quiet && $urandom_range(0, 3) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    // Present one word and hold it until the block takes it.
    task automatic send_word(input logic [63:0] operand);
        i_valid   <= 1'b1;
        i_operand <= operand;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
    endtask

    // Drop valid for a burst of the given number of clock edges.
    task automatic idle_sender(input int cycles);
        i_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Drop valid and wait until every predicted root has come back.
    task automatic hold_until_drained();
        i_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (ledger.pending() != 0);
    endtask

    // Draw an operand from a mix of shapes that stress the root recurrence.
    function automatic logic [63:0] pick_operand();
        logic [63:0] word;
        logic [63:0] k;
        word = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: ;                                            // full random
            1: word = 64'($urandom_range(0, 1000));         // tiny values
            2: begin
                // Perfect square, or one either side of it.
                k    = 64'($urandom_range(0, 32'd3037000499));
                word = k * k + 64'($urandom_range(0, 2)) - 64'd1;
            end
            3: word = word >> $urandom_range(0, 63);        // random magnitude
            4: word = word | (64'd1 << (isqrt_pkg::OPERAND_BITS - 1)); // force negative
            default: word = word & ~(64'd1 << (isqrt_pkg::OPERAND_BITS - 1));
        endcase
        return word;
    endfunction

    initial begin
        logic [63:0] corners [0:21];
        corners = '{
            64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd15, 64'd16, 64'd17,
            64'hFFFF_FFFF, 64'h1_0000_0000,
            64'h3FFF_FFFF_FFFF_FFFF, 64'h4000_0000_0000_0000,
            64'd9223372030926249001,            // largest perfect square
            64'd9223372030926249000,            // one below it
            64'h7FFF_FFFF_FFFF_FFFF,            // most positive
            64'h8000_0000_0000_0000,            // most negative
            64'hFFFF_FFFF_FFFF_FFFF,            // minus one
            64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
            64'h0000_0000_0000_00FF, 64'hDEAD_BEEF_0000_0001,
            64'h0123_4567_89AB_CDEF
        };

        quiet       = 1'b0;
        i_rst_n   <= 1'b0;
        i_valid   <= 1'b0;
        i_operand <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed corners, with a gap now and then.
        foreach (corners[n]) begin
            send_word(corners[n]);
            if ($urandom_range(0, 2) == 0)
                idle_sender($urandom_range(1, 10));
        end
        hold_until_drained();

        // Random operands; quiet tail with back-to-back words.
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n >= RANDOM_WORDS - QUIET_WORDS)
                quiet = 1'b1;
            send_word(pick_operand());
            if (!quiet && n % DRAIN_EVERY == DRAIN_EVERY - 1)
                hold_until_drained();
            else if (!quiet && $urandom_range(0, 3) == 0)
                idle_sender($urandom_range(1, 10));
        end

        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (ledger.pending() != 0) begin
            $display("%0t: %0d expected root words never arrived",
                     $time, ledger.pending());
            ledger.mismatches++;
        end

        if (ledger.mismatches == 0)
            $display("PASS integer_square_root");
        else
            $display("FAIL integer_square_root");
        $finish;
    end

endmodule
